>>> hdl/eight_op_processor_core_macros.svh
// Assertion macros used by the checker file.
`ifndef EIGHT_OP_PROCESSOR_CORE_MACROS_SVH
`define EIGHT_OP_PROCESSOR_CORE_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define EOPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eopc: same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define EOPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eopc: next-cycle check failed");

`endif

>>> hdl/eopc_pkg.sv
package eopc_pkg;

  // Storage geometry
  localparam int MEM_DEPTH = 65536;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int REG_COUNT = 8;
  localparam int REG_AW    = $clog2(REG_COUNT);

  // Fixed field widths
  localparam int WORD_W = 32;
  localparam int ADDR_W = 16;
  localparam int PC_W   = 16;
  localparam int OFF_W  = 16;

  // Instruction word layout
  localparam int OPC_LSB = 22;
  localparam int OPC_W   = 3;
  localparam int RA_LSB  = 19;
  localparam int RB_LSB  = 16;

  // Item operations
  typedef enum logic [1:0] {
    ITEM_WR_MEM = 2'd0,
    ITEM_RD_MEM = 2'd1,
    ITEM_EXEC   = 2'd2,
    ITEM_RD_REG = 2'd3
  } item_op_t;

  // Instruction opcodes
  typedef enum logic [OPC_W-1:0] {
    OPC_ADD  = 3'd0,
    OPC_NOR  = 3'd1,
    OPC_LW   = 3'd2,
    OPC_SW   = 3'd3,
    OPC_BEQ  = 3'd4,
    OPC_JALR = 3'd5,
    OPC_HALT = 3'd6,
    OPC_NOOP = 3'd7
  } opcode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RDM,
    S_RDR,
    S_FETCH,
    S_EXEC,
    S_LOAD,
    S_EMIT
  } state_t;

endpackage

>>> hdl/eopc_if.sv
// Input item channel
interface eopc_in_if;
  logic                  valid;
  logic                  ready;
  eopc_pkg::item_op_t    op;
  logic [15:0]           addr;
  logic signed [31:0]    wdata;

  modport source (output valid, op, addr, wdata, input ready);
  modport sink   (input valid, op, addr, wdata, output ready);
endinterface

// Result item channel
interface eopc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rdata;
  logic [15:0]        prog_counter;
  logic               halted;
  logic [31:0]        executed;

  modport source (output valid, rdata, prog_counter, halted, executed, input ready);
  modport sink   (input valid, rdata, prog_counter, halted, executed, output ready);
endinterface

>>> hdl/eight_op_processor_core.sv
// Eight-opcode 32-bit processor core with eight registers and a 64K-word memory.
// Each input transfer writes a memory word, reads a memory word or a
// register, or executes the instruction at the program counter (fetch,
// register read, execute; a load adds a write-back step because its data
// comes through the same single-port word memory, whose read is registered).
// An execute item after halt changes nothing. A new item is taken in the
// cycle its predecessor's result moves into the output register, so a result
// may wait there while the next item is taken and run up to its own output.
// Words of the memory read before they are ever written return undefined data;
// there is no clearing pass. The register file reads as zero after reset.
module eight_op_processor_core (
  input  logic        clk,
  input  logic        rst_n,
  eopc_in_if.sink     in_ch,
  eopc_out_if.source  out_ch
);
  import eopc_pkg::*;

  state_t                state_r, state_nxt, accept_state;
  logic                  slot_free, in_ready, in_xfer, emit;

  // Word memory port
  logic [WORD_W-1:0]     word_mem [MEM_DEPTH];
  logic [MEM_AW-1:0]     mem_addr;
  logic                  mem_we;
  logic [WORD_W-1:0]     mem_wdata;
  logic [WORD_W-1:0]     mem_q;

  // Register file ports
  logic [WORD_W-1:0]     reg_mem [REG_COUNT];
  logic [REG_COUNT-1:0]  reg_valid_r;
  logic [REG_AW-1:0]     rf_ra_addr, rf_rb_addr, rf_waddr;
  logic                  rf_we;
  logic [WORD_W-1:0]     rf_wdata;
  logic [WORD_W-1:0]     rf_a_q, rf_b_q;
  logic                  rf_va_q, rf_vb_q;

  // Architectural state
  logic [MEM_AW-1:0]     pc_r, pc_nxt;
  logic                  halt_r;
  logic [WORD_W-1:0]     exec_cnt_r;
  logic [WORD_W-1:0]     ir_r;
  logic [WORD_W-1:0]     res_r;

  // Decode and execute
  opcode_t               opc;
  logic [REG_AW-1:0]     fld_ra, fld_rb, fld_rd;
  logic [WORD_W-1:0]     off_ext, a_val, b_val;
  logic [MEM_AW-1:0]     pc_inc, br_tgt, eff_addr;

  // Output register
  logic                  out_valid_r;
  logic [WORD_W-1:0]     out_rdata_r;
  logic [PC_W-1:0]       out_pc_r;
  logic                  out_halted_r;
  logic [WORD_W-1:0]     out_exec_r;

  // Handshake
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_EMIT) && slot_free);
  assign in_xfer   = in_ch.valid && in_ready;
  assign emit      = (state_r == S_EMIT) && slot_free;
  assign in_ch.ready = in_ready;

  // Decode the held instruction word
  assign opc      = opcode_t'(ir_r[OPC_LSB +: OPC_W]);
  assign fld_ra   = ir_r[RA_LSB +: REG_AW];
  assign fld_rb   = ir_r[RB_LSB +: REG_AW];
  assign fld_rd   = ir_r[REG_AW-1:0];
  assign off_ext  = {{(WORD_W-OFF_W){ir_r[OFF_W-1]}}, ir_r[OFF_W-1:0]};
  assign a_val    = rf_va_q ? rf_a_q : '0;
  assign b_val    = rf_vb_q ? rf_b_q : '0;
  assign pc_inc   = pc_r + 1'b1;
  assign br_tgt   = pc_inc + off_ext[MEM_AW-1:0];
  assign eff_addr = a_val[MEM_AW-1:0] + off_ext[MEM_AW-1:0];

  // Pick the state that follows an accepted item
  always_comb begin
    unique case (in_ch.op)
      ITEM_WR_MEM: accept_state = S_EMIT;
      ITEM_RD_MEM: accept_state = S_RDM;
      ITEM_EXEC:   accept_state = halt_r ? S_EMIT : S_FETCH;
      ITEM_RD_REG: accept_state = S_RDR;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = accept_state;
      S_RDM:   state_nxt = S_EMIT;
      S_RDR:   state_nxt = S_EMIT;
      S_FETCH: state_nxt = S_EXEC;
      S_EXEC:  state_nxt = (opc == OPC_LW) ? S_LOAD : S_EMIT;
      S_LOAD:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (emit) state_nxt = in_xfer ? accept_state : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory and register file port control
  always_comb begin
    mem_we     = 1'b0;
    mem_addr   = in_ch.addr[MEM_AW-1:0];
    mem_wdata  = in_ch.wdata;
    rf_ra_addr = in_ch.addr[REG_AW-1:0];
    rf_rb_addr = fld_rb;
    rf_we      = 1'b0;
    rf_waddr   = fld_rd;
    rf_wdata   = a_val + b_val;
    unique case (state_r)
      S_IDLE, S_EMIT: begin
        if (in_xfer) begin
          if (in_ch.op == ITEM_WR_MEM) mem_we = 1'b1;
          if (in_ch.op == ITEM_EXEC) mem_addr = pc_r;
        end
      end
      S_FETCH: begin
        rf_ra_addr = mem_q[RA_LSB +: REG_AW];
        rf_rb_addr = mem_q[RB_LSB +: REG_AW];
      end
      S_EXEC: begin
        unique case (opc)
          OPC_ADD: rf_we = 1'b1;
          OPC_NOR: begin
            rf_we    = 1'b1;
            rf_wdata = ~(a_val | b_val);
          end
          OPC_LW: mem_addr = eff_addr;
          OPC_SW: begin
            mem_we    = 1'b1;
            mem_addr  = eff_addr;
            mem_wdata = b_val;
          end
          OPC_JALR: begin
            rf_we    = 1'b1;
            rf_waddr = fld_rb;
            rf_wdata = WORD_W'(pc_inc);
          end
          default: ;
        endcase
      end
      S_LOAD: begin
        rf_we    = 1'b1;
        rf_waddr = fld_rb;
        rf_wdata = mem_q;
      end
      default: ;
    endcase
  end

  // Program counter after the executed instruction
  always_comb begin
    pc_nxt = pc_inc;
    if ((opc == OPC_BEQ) && (a_val == b_val)) pc_nxt = br_tgt;
    if ((opc == OPC_JALR) && (fld_ra != fld_rb)) pc_nxt = a_val[MEM_AW-1:0];
  end

  // Word memory: one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) word_mem[mem_addr] <= mem_wdata;
    mem_q <= word_mem[mem_addr];
  end

  // Register file: two registered reads, one write
  always_ff @(posedge clk) begin
    if (rf_we) reg_mem[rf_waddr] <= rf_wdata;
    rf_a_q <= reg_mem[rf_ra_addr];
    rf_b_q <= reg_mem[rf_rb_addr];
  end

  // Track written registers; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_valid_r <= '0;
      rf_va_q     <= 1'b0;
      rf_vb_q     <= 1'b0;
    end else begin
      if (rf_we) reg_valid_r[rf_waddr] <= 1'b1;
      rf_va_q <= reg_valid_r[rf_ra_addr];
      rf_vb_q <= reg_valid_r[rf_rb_addr];
    end
  end

  // Sequencer and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pc_r       <= '0;
      halt_r     <= 1'b0;
      exec_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EXEC) begin
        pc_r <= pc_nxt;
        if (opc == OPC_HALT) halt_r <= 1'b1;
        if (exec_cnt_r != '1) exec_cnt_r <= exec_cnt_r + 1'b1;
      end
    end
  end

  // Hold the instruction word and the read result
  always_ff @(posedge clk) begin
    if (state_r == S_FETCH) ir_r <= mem_q;
    if (in_xfer) begin
      res_r <= '0;
    end else if (state_r == S_RDM) begin
      res_r <= mem_q;
    end else if (state_r == S_RDR) begin
      res_r <= rf_va_q ? rf_a_q : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_rdata_r  <= res_r;
      out_pc_r     <= PC_W'(pc_r);
      out_halted_r <= halt_r;
      out_exec_r   <= exec_cnt_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.rdata        = out_rdata_r;
  assign out_ch.prog_counter = out_pc_r;
  assign out_ch.halted       = out_halted_r;
  assign out_ch.executed     = out_exec_r;

endmodule

>>> hdl/eopc_checker.sv
`include "eight_op_processor_core_macros.svh"

module eopc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_rdata,
  input logic [15:0] out_prog_counter,
  input logic        out_halted,
  input logic [31:0] out_executed
);

  logic        out_stall;
  logic [80:0] out_payload;

  assign out_stall   = out_valid && !out_ready;
  assign out_payload = {out_rdata, out_prog_counter, out_halted, out_executed};

  // Hold a stalled result
  `EOPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_payload))

  // Keep halted once shown
  `EOPC_ASSERT_NEXT(a_halt_sticky, clk, rst_n, out_valid && out_halted, out_halted)

  // Freeze the program counter after halt
  `EOPC_ASSERT_NEXT(a_halt_pc_frozen, clk, rst_n, out_valid && out_halted, $stable(out_prog_counter))

  // Count the halt instruction itself
  `EOPC_ASSERT_SAME(a_halt_counted, clk, rst_n, out_valid && out_halted, out_executed != 32'd0)

endmodule

bind eight_op_processor_core eopc_checker u_eopc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_rdata        (out_ch.rdata),
  .out_prog_counter (out_ch.prog_counter),
  .out_halted       (out_ch.halted),
  .out_executed     (out_ch.executed)
);
